// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file hrc_checker.sv.
// The including scope must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define HRC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define HRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define HRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hrc_pkg.sv =====
// Types and codes of the hysteresis relay controller.
// No dependencies; imported by hrc_regs, hrc_decide and the top level.
package hrc_pkg;

  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned MEAS_W = 16;
  localparam int unsigned DUR_W  = 32;

  typedef enum logic [2:0] {
    MODE_SWITCH     = 3'd0,
    MODE_COOL       = 3'd1,
    MODE_HEAT       = 3'd2,
    MODE_HUMIDIFY   = 3'd3,
    MODE_DEHUMIDIFY = 3'd4,
    MODE_CYCLE      = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_BASE     = 3'd1,
    REG_BAND     = 3'd2,
    REG_ON_DUR   = 3'd3,
    REG_OFF_DUR  = 3'd4,
    REG_INVERT   = 3'd5
  } reg_idx_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [2:0]       mode;
    logic [7:0]       base_level;
    logic [7:0]       band;
    logic [DUR_W-1:0] on_duration;
    logic [DUR_W-1:0] off_duration;
    logic             invert_output;
  } cfg_t;

  typedef struct packed {
    logic relay_on;
    logic pin_level;
    logic switched;
  } res_t;

endpackage

// ===== sv/hrc_in_if.sv =====
// Input stream channel: one beat carries an opcode and a measurement.
// Depends on nothing.
interface hrc_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [15:0] measurement;

  modport source (output valid, output opcode, output measurement, input ready);
  modport sink   (input valid, input opcode, input measurement, output ready);
endinterface

// ===== sv/hrc_out_if.sv =====
// Output stream channel: one beat carries the relay result.
// Depends on nothing.
interface hrc_out_if;
  logic valid;
  logic ready;
  logic relay_on;
  logic pin_level;
  logic switched;

  modport source (output valid, output relay_on, output pin_level, output switched,
                  input ready);
  modport sink   (input valid, input relay_on, input pin_level, input switched,
                  output ready);
endinterface

// ===== sv/hrc_regs.sv =====
// APB register file holding the controller configuration.
// Depends on hrc_pkg.
module hrc_regs
  import hrc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_MODE:    cfg_d.mode          = pwdata[2:0];
        REG_BASE:    cfg_d.base_level    = pwdata[7:0];
        REG_BAND:    cfg_d.band          = pwdata[7:0];
        REG_ON_DUR:  cfg_d.on_duration   = pwdata[DUR_W-1:0];
        REG_OFF_DUR: cfg_d.off_duration  = pwdata[DUR_W-1:0];
        REG_INVERT:  cfg_d.invert_output = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:    prdata = APB_DW'(cfg_q.mode);
      REG_BASE:    prdata = APB_DW'(cfg_q.base_level);
      REG_BAND:    prdata = APB_DW'(cfg_q.band);
      REG_ON_DUR:  prdata = APB_DW'(cfg_q.on_duration);
      REG_OFF_DUR: prdata = APB_DW'(cfg_q.off_duration);
      REG_INVERT:  prdata = APB_DW'(cfg_q.invert_output);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/hrc_decide.sv =====
// Relay decision logic and the relay, cycle and tick-count state.
// Depends on hrc_pkg; fed from the input register of the top level.
module hrc_decide
  import hrc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH    = 32,
  parameter int unsigned FRACTION_BITS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              opcode_i,
  input  logic [MEAS_W-1:0] measurement_i,
  input  cfg_t              cfg_i,
  output res_t              res_o
);

  localparam int unsigned CMP_W = 18 + FRACTION_BITS;
  localparam int unsigned CNT_W = (TIME_WIDTH > DUR_W) ? TIME_WIDTH : DUR_W;

  logic                  relay_q, relay_d;
  logic                  started_q, started_d;
  logic [TIME_WIDTH-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic                  sw;

  logic signed [CMP_W-1:0] m_ext, on_thr, off_lo, off_hi;
  logic signed [9:0]       lo_diff, hi_sum;
  logic [MEAS_W:0]         mag, mag_int;
  logic                    int_nonzero;

  assign m_ext   = CMP_W'($signed(measurement_i));
  assign on_thr  = $signed(CMP_W'(cfg_i.base_level)) <<< FRACTION_BITS;
  assign lo_diff = $signed({2'b00, cfg_i.base_level}) - $signed({2'b00, cfg_i.band});
  assign hi_sum  = $signed({2'b00, cfg_i.base_level}) + $signed({2'b00, cfg_i.band});
  assign off_lo  = CMP_W'(lo_diff) <<< FRACTION_BITS;
  assign off_hi  = CMP_W'(hi_sum) <<< FRACTION_BITS;

  // Integer part truncates toward zero, so work on the magnitude.
  assign mag         = measurement_i[MEAS_W-1]
                       ? ((MEAS_W+1)'(0) - {measurement_i[MEAS_W-1], measurement_i})
                       : {1'b0, measurement_i};
  assign mag_int     = mag >> FRACTION_BITS;
  assign int_nonzero = |mag_int[7:0];

  // Saturating tick count.
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + TIME_WIDTH'(1);

  always_comb begin
    relay_d   = relay_q;
    started_d = started_q;
    elapsed_d = elapsed_q;
    sw        = 1'b0;
    if (opcode_i == OP_SAMPLE) begin
      unique case (cfg_i.mode) inside
        MODE_SWITCH: begin
          relay_d = int_nonzero;
          sw      = 1'b1;
        end
        MODE_COOL, MODE_DEHUMIDIFY: begin
          if (!relay_q && (m_ext > on_thr)) begin
            relay_d = 1'b1;
            sw      = 1'b1;
          end else if (relay_q && (m_ext < off_lo)) begin
            relay_d = 1'b0;
            sw      = 1'b1;
          end
        end
        MODE_HEAT, MODE_HUMIDIFY: begin
          if (!relay_q && (m_ext < on_thr)) begin
            relay_d = 1'b1;
            sw      = 1'b1;
          end else if (relay_q && (m_ext > off_hi)) begin
            relay_d = 1'b0;
            sw      = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (cfg_i.mode == MODE_CYCLE) begin
      if (!started_q) begin
        started_d = 1'b1;
        relay_d   = 1'b1;
        elapsed_d = '0;
        sw        = 1'b1;
      end else if (!relay_q && (CNT_W'(elapsed_inc) >= CNT_W'(cfg_i.off_duration))) begin
        relay_d   = 1'b1;
        elapsed_d = '0;
        sw        = 1'b1;
      end else if (relay_q && (CNT_W'(elapsed_inc) >= CNT_W'(cfg_i.on_duration))) begin
        relay_d   = 1'b0;
        elapsed_d = '0;
        sw        = 1'b1;
      end else begin
        elapsed_d = elapsed_inc;
      end
    end
  end

  assign res_o.relay_on  = relay_d;
  assign res_o.pin_level = relay_d ^ cfg_i.invert_output;
  assign res_o.switched  = sw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q   <= 1'b0;
      started_q <= 1'b0;
      elapsed_q <= '0;
    end else if (step_i) begin
      relay_q   <= relay_d;
      started_q <= started_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

// ===== sv/hysteresis_relay_controller.sv =====
// Hysteresis relay controller, top level.
// Depends on hrc_pkg, hrc_in_if, hrc_out_if, hrc_regs and hrc_decide.
//
// Usage:
//   in_i carries one beat per measurement sample (opcode 0) or millisecond
//   tick (opcode 1). out_o returns exactly one beat per input beat, in order,
//   with the relay state, the pin level and a flag for an issued drive.
//   Configuration goes through the APB port (mode, base level, band, on and
//   off durations, output inversion) at byte addresses 0, 4, .. 20; write it
//   only while no beat is in flight.
// Timing:
//   A beat is held in the input register, the decision is taken while it
//   moves into the result register, and the result is offered from there.
//   One beat per cycle is sustained while out_o does not stall; the limit is
//   the single decide stage, whose state updates as each beat leaves it.
// Reset and stalls:
//   Reset clears the relay (off), the cycle start flag, the tick count and
//   all configuration. When out_o stalls, the result register holds and one
//   more beat parks in the input register; in_i then drops ready.
module hysteresis_relay_controller
  import hrc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH    = 32,
  parameter int unsigned FRACTION_BITS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hrc_in_if.sink            in_i,
  hrc_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t              cfg;
  res_t              res;
  logic              s1_valid_q;
  logic              s1_op_q;
  logic [MEAS_W-1:0] s1_meas_q;
  logic              out_valid_q;
  res_t              out_res_q;
  logic              out_free, s1_adv, in_fire;

  hrc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire    = in_i.valid && in_i.ready;

  hrc_decide #(
    .TIME_WIDTH    (TIME_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_decide (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (s1_adv),
    .opcode_i      (s1_op_q),
    .measurement_i (s1_meas_q),
    .cfg_i         (cfg),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers: load on a beat, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= in_i.opcode;
      s1_meas_q <= in_i.measurement;
    end
    if (s1_adv) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.relay_on  = out_res_q.relay_on;
  assign out_o.pin_level = out_res_q.pin_level;
  assign out_o.switched  = out_res_q.switched;

endmodule

// ===== sv/hrc_checker.sv =====
// Port-level checks of the hysteresis relay controller, bound to the top.
// Depends on assert_macros.svh and hrc_in_if, hrc_out_if.
`include "assert_macros.svh"

module hrc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_relay_on_i,
  input logic out_switched_i
);

  logic       in_beat, out_beat;
  logic [1:0] pend_q, pend_d;
  logic       last_relay_q;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_beat && !out_beat) begin
      pend_d = pend_q + 2'd1;
    end else if (!in_beat && out_beat) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      last_relay_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (out_beat) begin
        last_relay_q <= out_relay_on_i;
      end
    end
  end

  `HRC_ASSERT_NEXT(a_out_valid_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `HRC_ASSERT_IMPL(a_no_phantom, out_valid_i, pend_q != 2'd0, "result offered without an accepted beat")
  `HRC_ASSERT(a_depth, pend_q != 2'd3, "more beats in flight than the pipeline holds")
  `HRC_ASSERT_IMPL(a_change_flagged, out_beat && (out_relay_on_i != last_relay_q), out_switched_i, "relay changed without a drive")

endmodule

bind hysteresis_relay_controller hrc_checker u_hrc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_relay_on_i (out_o.relay_on),
  .out_switched_i (out_o.switched)
);
